[rtl/core/aqssc_pkg.sv]
// shared types and constants for the quaternion attitude controller
package aqssc_pkg;

  localparam int unsigned NumRegs = 6;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [2:0] {
    REG_COEF_A   = 3'd0,
    REG_COEF_B   = 3'd1,
    REG_COEF_C   = 3'd2,
    REG_COEF_D   = 3'd3,
    REG_YAW_ATT  = 3'd4,
    REG_YAW_RATE = 3'd5
  } reg_idx_e;

  // divider request and response between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PROD,
    ST_DIV4,
    ST_SQ,
    ST_SQRT,
    ST_NDIV,
    ST_NWAIT,
    ST_FILT,
    ST_YMUL,
    ST_YDIV,
    ST_YWAIT,
    ST_OUT
  } state_e;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) sat32 = 32'sh7fffffff;
    else if (x < lo) sat32 = 32'sh80000000;
    else sat32 = x[31:0];
  endfunction

  // Q32.32 to Q16.16, round half up (floor of x + 0.5)
  function automatic logic signed [65:0] round16(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = x + 66'sd32768;
    round16 = t >>> 16;
  endfunction

endpackage

[rtl/core/aqssc_div.sv]
// radix-2 restoring divider for 64-bit unsigned operands, one bit per cycle
module aqssc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  aqssc_pkg::div_req_t req_i,
  output aqssc_pkg::div_rsp_t rsp_o
);
  import aqssc_pkg::*;

  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] quot_q, quot_d;
  logic [64:0] rem_q, rem_d;
  logic [63:0] den_q, den_d;
  logic [64:0] trial;

  // one shift-subtract step per cycle
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[63:0], quot_q[63]} - {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 7'd64;
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d  = trial;
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = {rem_q[63:0], quot_q[63]};
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
endmodule

[rtl/core/attitude_quat_state_space_controller.sv]
// top level of the quaternion attitude controller with state-space roll/pitch filters
//
// One item is taken at a time; s_axis_tready is low while it is worked on. An item in flight
// goes through 16 products on the shared 34x34 multiplier, a scaling step, four squares, a
// 32-step square root, three divisions of the normalizing divider (x, y and z parts), eight
// filter products, one yaw product and a yaw division, then an output step that loads the
// output register. A zero yaw rate gain skips the yaw division, and a zero-length error skips
// the normalizing divisions. A not-in-flight item goes straight from idle to the output step.
// The result sits in an output register until taken; the next item is taken once it is gone.
module attitude_quat_state_space_controller (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [aqssc_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // meas_w, meas_x, meas_y, meas_z, target_w, target_x, target_y, target_z,
  // ff_roll, ff_pitch, ff_yaw
  input  logic [223:0] s_axis_tdata,
  // in_flight
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rate_roll, rate_pitch, rate_yaw
  output logic [95:0]  m_axis_tdata,
  // yaw_div_fault
  output logic         m_axis_tuser
);
  import aqssc_pkg::*;

  // configuration registers
  logic signed [31:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q;
  logic [31:0] yaw_att_q, yaw_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_a_q   <= '0;
      coef_b_q   <= '0;
      coef_c_q   <= '0;
      coef_d_q   <= '0;
      yaw_att_q  <= 32'd65536;
      yaw_rate_q <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COEF_A:   coef_a_q   <= cfg_data_i;
        REG_COEF_B:   coef_b_q   <= cfg_data_i;
        REG_COEF_C:   coef_c_q   <= cfg_data_i;
        REG_COEF_D:   coef_d_q   <= cfg_data_i;
        REG_YAW_ATT:  yaw_att_q  <= cfg_data_i;
        REG_YAW_RATE: yaw_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [4:0] step_q, step_d;

  // captured input item
  logic signed [15:0] m_q [4];
  logic signed [15:0] t_q [4];
  logic signed [31:0] ffr_q, ffp_q, ffy_q;

  // working values
  logic signed [33:0] u_q [4];
  logic signed [33:0] u_d [4];
  logic [63:0] sumsq_q, sumsq_d;
  logic [63:0] sq_n_q, sq_n_d, sq_r_q, sq_r_d, sq_b_q, sq_b_d;
  logic signed [17:0] e_q [4];
  logic signed [17:0] e_d [4];
  logic signed [65:0] acc_q, acc_d;
  logic signed [31:0] s_roll_q, s_roll_d, s_pitch_q, s_pitch_d;
  logic [63:0] ynum_q, ynum_d;
  logic signed [31:0] o_roll_q, o_roll_d, o_pitch_q, o_pitch_d, o_yaw_q, o_yaw_d;
  logic o_fault_q, o_fault_d;
  logic out_vld_q, out_vld_d;

  div_req_t dreq;
  div_rsp_t drsp;

  aqssc_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // shared multiplier operands
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  assign mul_p = mul_a * mul_b;

  wire accept_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !out_vld_q;

  // product term table: component, m index, t index, sign
  logic [1:0] p_mi, p_ti;
  logic       p_neg;
  always_comb begin
    p_mi  = step_q[1:0];
    p_ti  = 2'd0;
    p_neg = 1'b0;
    unique case (step_q[3:2])
      2'd0: begin p_ti = step_q[1:0]; end
      2'd1: begin
        unique case (step_q[1:0])
          2'd0: p_ti = 2'd1;
          2'd1: begin p_ti = 2'd0; p_neg = 1'b1; end
          2'd2: begin p_ti = 2'd3; p_neg = 1'b1; end
          default: p_ti = 2'd2;
        endcase
      end
      2'd2: begin
        unique case (step_q[1:0])
          2'd0: p_ti = 2'd2;
          2'd1: p_ti = 2'd3;
          2'd2: begin p_ti = 2'd0; p_neg = 1'b1; end
          default: begin p_ti = 2'd1; p_neg = 1'b1; end
        endcase
      end
      default: begin
        unique case (step_q[1:0])
          2'd0: p_ti = 2'd3;
          2'd1: begin p_ti = 2'd2; p_neg = 1'b1; end
          2'd2: p_ti = 2'd1;
          default: begin p_ti = 2'd0; p_neg = 1'b1; end
        endcase
      end
    endcase
  end

  // filter step operands: step 0..7 = roll C*s, D*e, A*s, B*e, then pitch
  logic signed [31:0] f_coef;
  logic signed [33:0] f_val;
  always_comb begin
    unique case (step_q[1:0])
      2'd0: f_coef = coef_c_q;
      2'd1: f_coef = coef_d_q;
      2'd2: f_coef = coef_a_q;
      default: f_coef = coef_b_q;
    endcase
    if (step_q[0]) f_val = 34'(step_q[2] ? e_q[2] : e_q[1]);
    else f_val = 34'(step_q[2] ? s_pitch_q : s_roll_q);
  end

  // square root trial
  logic [63:0] sq_sum;
  assign sq_sum = sq_r_q + sq_b_q;

  // magnitudes for normalizing and yaw
  logic [33:0] u_mag;
  assign u_mag = u_q[step_q[1:0]][33] ? 34'(-u_q[step_q[1:0]]) : 34'(u_q[step_q[1:0]]);
  logic [17:0] ez_mag;
  assign ez_mag = e_q[3][17] ? 18'(-e_q[3]) : 18'(e_q[3]);

  logic signed [65:0] rnd, ff_sel, yq;
  logic signed [31:0] sat_r;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept_in) state_d = s_axis_tuser ? ST_PROD : ST_OUT;
      ST_PROD:  if (step_q == 5'd15) state_d = ST_DIV4;
      ST_DIV4:  state_d = ST_SQ;
      ST_SQ:    if (step_q == 5'd3) state_d = ST_SQRT;
      ST_SQRT:  if (step_q == 5'd31) state_d = ST_NDIV;
      ST_NDIV:  state_d = ST_NWAIT;
      ST_NWAIT: begin
        if (sq_r_q == '0 || drsp.done) state_d = (step_q == 5'd3) ? ST_FILT : ST_NDIV;
      end
      ST_FILT:  if (step_q == 5'd7) state_d = ST_YMUL;
      ST_YMUL:  state_d = (yaw_rate_q == '0) ? ST_OUT : ST_YDIV;
      ST_YDIV:  state_d = ST_YWAIT;
      ST_YWAIT: if (drsp.done) state_d = ST_OUT;
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    step_d    = step_q;
    u_d       = u_q;
    sumsq_d   = sumsq_q;
    sq_n_d    = sq_n_q;
    sq_r_d    = sq_r_q;
    sq_b_d    = sq_b_q;
    e_d       = e_q;
    acc_d     = acc_q;
    s_roll_d  = s_roll_q;
    s_pitch_d = s_pitch_q;
    ynum_d    = ynum_q;
    o_roll_d  = o_roll_q;
    o_pitch_d = o_pitch_q;
    o_yaw_d   = o_yaw_q;
    o_fault_d = o_fault_q;
    out_vld_d = out_vld_q;
    dreq      = '0;
    mul_a     = '0;
    mul_b     = '0;
    rnd       = '0;
    ff_sel    = '0;
    yq        = '0;
    sat_r     = '0;
    if (out_vld_q && m_axis_tready) out_vld_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        for (int i = 0; i < 4; i++) u_d[i] = '0;
        if (accept_in && !s_axis_tuser) begin
          s_roll_d  = '0;
          s_pitch_d = '0;
          o_roll_d  = '0;
          o_pitch_d = '0;
          o_yaw_d   = '0;
          o_fault_d = 1'b0;
        end
      end
      ST_PROD: begin
        mul_a = 34'(m_q[p_mi]);
        mul_b = 34'(t_q[p_ti]);
        if (p_neg) u_d[step_q[3:2]] = u_q[step_q[3:2]] - mul_p[33:0];
        else u_d[step_q[3:2]] = u_q[step_q[3:2]] + mul_p[33:0];
        step_d = (step_q == 5'd15) ? '0 : step_q + 5'd1;
      end
      ST_DIV4: begin
        // divide by four toward zero, then pick the short rotation
        for (int i = 0; i < 4; i++) begin
          u_d[i] = (u_q[i][33] ? (u_q[i] + 34'sd3) : u_q[i]) >>> 2;
        end
        if (u_d[0][33]) for (int i = 0; i < 4; i++) u_d[i] = -u_d[i];
        sumsq_d = '0;
      end
      ST_SQ: begin
        mul_a   = u_q[step_q[1:0]];
        mul_b   = u_q[step_q[1:0]];
        sumsq_d = sumsq_q + mul_p[63:0];
        step_d  = (step_q == 5'd3) ? '0 : step_q + 5'd1;
        if (step_q == 5'd3) begin
          sq_n_d = sumsq_q + mul_p[63:0];
          sq_r_d = '0;
          sq_b_d = 64'h4000_0000_0000_0000;
        end
      end
      ST_SQRT: begin
        if (sq_n_q >= sq_sum) begin
          sq_n_d = sq_n_q - sq_sum;
          sq_r_d = (sq_r_q >> 1) + sq_b_q;
        end else begin
          sq_r_d = sq_r_q >> 1;
        end
        sq_b_d = sq_b_q >> 2;
        step_d = (step_q == 5'd31) ? 5'd1 : step_q + 5'd1;
      end
      ST_NDIV: begin
        dreq.start = (sq_r_q != '0);
        dreq.num   = {u_mag, 17'd0} + sq_r_q;
        dreq.den   = {sq_r_q[62:0], 1'b0};
        if (sq_r_q == '0) e_d[step_q[1:0]] = '0;
      end
      ST_NWAIT: begin
        if (sq_r_q == '0 || drsp.done) begin
          if (sq_r_q != '0) begin
            e_d[step_q[1:0]] = u_q[step_q[1:0]][33] ? 18'(-drsp.quot[17:0])
                                                    : drsp.quot[17:0];
          end
          step_d = (step_q == 5'd3) ? '0 : step_q + 5'd1;
        end
      end
      ST_FILT: begin
        mul_a = 34'(f_coef);
        mul_b = f_val;
        if (!step_q[0]) acc_d = 66'(mul_p);
        else begin
          rnd = round16(acc_q + 66'(mul_p));
          if (!step_q[1]) begin
            ff_sel = step_q[2] ? 66'(ffp_q) : 66'(ffr_q);
            sat_r  = sat32(rnd + ff_sel);
            if (step_q[2]) o_pitch_d = sat_r; else o_roll_d = sat_r;
          end else begin
            sat_r = sat32(rnd);
            if (step_q[2]) s_pitch_d = sat_r; else s_roll_d = sat_r;
          end
        end
        step_d = (step_q == 5'd7) ? '0 : step_q + 5'd1;
      end
      ST_YMUL: begin
        mul_a  = 34'({2'b00, yaw_att_q});
        mul_b  = 34'(ez_mag);
        ynum_d = mul_p[63:0];
        o_fault_d = (yaw_rate_q == '0);
        if (yaw_rate_q == '0) begin
          if (mul_p[63:0] == '0) o_yaw_d = ffy_q;
          else o_yaw_d = e_q[3][17] ? 32'sh80000000 : 32'sh7fffffff;
        end
      end
      ST_YDIV: begin
        dreq.start = 1'b1;
        dreq.num   = {ynum_q[62:0], 1'b0} + 64'(yaw_rate_q);
        dreq.den   = {31'd0, yaw_rate_q, 1'b0};
      end
      ST_YWAIT: begin
        if (drsp.done) begin
          yq = e_q[3][17] ? -66'(drsp.quot) : 66'(drsp.quot);
          o_yaw_d = sat32(yq + 66'(ffy_q));
        end
      end
      ST_OUT: out_vld_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      out_vld_q <= 1'b0;
      s_roll_q  <= '0;
      s_pitch_q <= '0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      out_vld_q <= out_vld_d;
      s_roll_q  <= s_roll_d;
      s_pitch_q <= s_pitch_d;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      for (int i = 0; i < 4; i++) begin
        m_q[i] <= s_axis_tdata[16*i +: 16];
        t_q[i] <= s_axis_tdata[64 + 16*i +: 16];
      end
      ffr_q <= s_axis_tdata[159:128];
      ffp_q <= s_axis_tdata[191:160];
      ffy_q <= s_axis_tdata[223:192];
    end
    u_q       <= u_d;
    sumsq_q   <= sumsq_d;
    sq_n_q    <= sq_n_d;
    sq_r_q    <= sq_r_d;
    sq_b_q    <= sq_b_d;
    e_q       <= e_d;
    acc_q     <= acc_d;
    ynum_q    <= ynum_d;
    o_roll_q  <= o_roll_d;
    o_pitch_q <= o_pitch_d;
    o_yaw_q   <= o_yaw_d;
    o_fault_q <= o_fault_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {o_yaw_q, o_pitch_q, o_roll_q};
  assign m_axis_tuser  = o_fault_q;

`ifndef SYNTHESIS
  // no new item while a result waits
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !s_axis_tready) else $error("input taken while result pending");
  // divider only started when idle
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> !drsp.busy) else $error("divider restarted while busy");
  // result appears only after the output step
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q) == ST_OUT) else $error("stray result");
`endif
endmodule
